[rtl/core/mersenne_twister_64_generator_unit_assert.svh]
// ----------------------------------------------------------------------------
// MT19937-64 assertion macros
// Shared property forms for the generator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_64_GENERATOR_UNIT_ASSERT_SVH
`define MERSENNE_TWISTER_64_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MT64_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mt64 same-cycle check failed");

// next-cycle implication
`define MT64_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mt64 next-cycle check failed");

`endif

[rtl/core/mt64_pkg.sv]
// ----------------------------------------------------------------------------
// MT19937-64 package
// Widths, constants and the state write request shared by the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mt64_pkg;

	localparam int STATE_WORDS   = 312;
	localparam int MIDDLE_OFFSET = 156;
	localparam int ADDR_W        = 9;
	localparam int WORD_W        = 64;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam addr_t LAST_IDX = addr_t'(STATE_WORDS - 1);
	localparam addr_t MID_IDX  = addr_t'(MIDDLE_OFFSET);

	localparam word_t SEED_RESET = 64'd5489;
	localparam logic [31:0] MULT_LO = 32'h4C957F2D;
	localparam logic [31:0] MULT_HI = 32'h5851F42D;

	localparam word_t TWIST_MATRIX = 64'hB5026F5AA96619E9;
	localparam word_t HIGH_MASK    = 64'hFFFFFFFF80000000;
	localparam word_t LOW_MASK     = 64'h000000007FFFFFFF;

	localparam word_t TEMPER_D = 64'h5555555555555555;
	localparam word_t TEMPER_B = 64'h71D67FFFEDA60000;
	localparam word_t TEMPER_C = 64'hFFF7EEE000000000;

	typedef struct packed {
		logic  we;
		addr_t addr;
		word_t data;
	} wr_req_t;

endpackage

`default_nettype wire

[rtl/core/mt64_seed_fill.sv]
// ----------------------------------------------------------------------------
// MT19937-64 seed fill
// Produces the 312 seed words w[k] = M * (w[k-1] ^ (w[k-1] >> 62)) + k as
// a stream of state writes; each word after the first passes a multiply and an add state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mt64_seed_fill (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mt64_pkg::word_t  seed,
	output mt64_pkg::wr_req_t     wr,
	output logic                  busy
);

	typedef enum logic [1:0] {F_IDLE, F_FIRST, F_MUL, F_ADD} fstate_t;

	fstate_t         state_q;
	mt64_pkg::word_t prev_q;
	mt64_pkg::addr_t k_q;
	mt64_pkg::word_t ll_s1;
	logic [31:0]     cr_s1;

	mt64_pkg::word_t x;
	mt64_pkg::word_t sum;

	assign x   = prev_q ^ (prev_q >> 62);
	assign sum = ll_s1 + {cr_s1, 32'b0} + mt64_pkg::word_t'(k_q);

	always_comb begin
		wr.we   = 1'b0;
		wr.addr = k_q;
		wr.data = sum;
		unique case (state_q)
			F_FIRST: begin
				wr.we   = 1'b1;
				wr.addr = '0;
				wr.data = seed;
			end
			F_ADD:   wr.we = 1'b1;
			default: wr.we = 1'b0;
		endcase
	end

	assign busy = (state_q != F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_FIRST;
			k_q     <= '0;
		end else if (start) begin
			state_q <= F_FIRST;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: state_q <= F_IDLE;
				F_FIRST: begin
					k_q     <= mt64_pkg::addr_t'(1);
					state_q <= F_MUL;
				end
				F_MUL: state_q <= F_ADD;
				F_ADD: begin
					if (k_q == mt64_pkg::LAST_IDX) begin
						state_q <= F_IDLE;
					end else begin
						k_q     <= k_q + mt64_pkg::addr_t'(1);
						state_q <= F_MUL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_FIRST) begin
			prev_q <= seed;
		end else if (state_q == F_ADD) begin
			prev_q <= sum;
		end
		ll_s1 <= mt64_pkg::word_t'(x[31:0]) * mt64_pkg::word_t'(mt64_pkg::MULT_LO);
		cr_s1 <= 32'(x[63:32] * mt64_pkg::MULT_LO) + 32'(x[31:0] * mt64_pkg::MULT_HI);
	end

endmodule

`default_nettype wire

[rtl/core/mersenne_twister_64_generator_unit.sv]
// ----------------------------------------------------------------------------
// MT19937-64 generator unit
// Holds the 312-word state in a 1-write/2-read synchronous RAM and twists
// each word just before it is tempered and returned.
//
//   channel | direction | handshake                | payload
//   draw    | in        | draw_valid / draw_stall  | draw_request
//   word    | out       | word_valid / word_stall  | random_word
//   seed    | in        | seed_valid / seed_ready  | seed_value
//
// A draw passes the RAM reads of w[i+156] and w[i+1], then S_CALC, which
// twists, writes back w[i] and tempers. The word after i is kept in a register.
// After reset and after every seed write the state is refilled (one multiply
// stage and one add stage per word after the first); draws stall meanwhile.
// A finished word waits in a skid entry under word_stall; draws stall meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_64_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        draw_valid,
	output logic             draw_stall,
	input  wire logic        draw_request,
	output logic             word_valid,
	input  wire logic        word_stall,
	output logic [63:0]      random_word,
	input  wire logic        seed_valid,
	output logic             seed_ready,
	input  wire logic [63:0] seed_value
);

	typedef enum logic {S_IDLE, S_CALC} state_t;

	state_t              state_q;
	mt64_pkg::addr_t     ptr_q;
	mt64_pkg::word_t     seed_q;
	mt64_pkg::word_t     cur_q;
	logic                word_valid_q;
	mt64_pkg::word_t     word_q;
	logic                pend_q;
	mt64_pkg::word_t     pend_data_q;

	mt64_pkg::word_t     mem [mt64_pkg::STATE_WORDS];
	mt64_pkg::word_t     rd_mid_q;
	mt64_pkg::word_t     rd_nxt_q;

	mt64_pkg::wr_req_t   fill_wr;
	logic                fill_busy;

	mt64_pkg::addr_t     nxt_addr;
	mt64_pkg::addr_t     mid_addr;
	mt64_pkg::word_t     y;
	mt64_pkg::word_t     twisted;
	mt64_pkg::word_t     tempered;
	logic                draw_go;
	logic                mem_we;
	mt64_pkg::addr_t     mem_wa;
	mt64_pkg::word_t     mem_wd;

	function automatic mt64_pkg::word_t temper(input mt64_pkg::word_t v);
		mt64_pkg::word_t t;
		t = v;
		t = t ^ ((t >> 29) & mt64_pkg::TEMPER_D);
		t = t ^ ((t << 17) & mt64_pkg::TEMPER_B);
		t = t ^ ((t << 37) & mt64_pkg::TEMPER_C);
		t = t ^ (t >> 43);
		return t;
	endfunction

	mt64_seed_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_valid),
		.seed   (seed_q),
		.wr     (fill_wr),
		.busy   (fill_busy)
	);

	assign seed_ready  = 1'b1;
	assign draw_stall  = fill_busy || (state_q != S_IDLE) || pend_q;
	assign word_valid  = word_valid_q;
	assign random_word = word_q;

	assign draw_go  = draw_valid && !draw_stall && draw_request;
	assign nxt_addr = (ptr_q == mt64_pkg::LAST_IDX) ? '0 : ptr_q + mt64_pkg::addr_t'(1);
	assign mid_addr = (ptr_q < mt64_pkg::MID_IDX) ? ptr_q + mt64_pkg::MID_IDX
	                                              : ptr_q - mt64_pkg::MID_IDX;

	assign y        = (cur_q & mt64_pkg::HIGH_MASK) | (rd_nxt_q & mt64_pkg::LOW_MASK);
	assign twisted  = rd_mid_q ^ (y >> 1) ^ (y[0] ? mt64_pkg::TWIST_MATRIX : '0);
	assign tempered = temper(twisted);

	always_comb begin
		if (fill_busy) begin
			mem_we = fill_wr.we;
			mem_wa = fill_wr.addr;
			mem_wd = fill_wr.data;
		end else begin
			mem_we = (state_q == S_CALC);
			mem_wa = ptr_q;
			mem_wd = twisted;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_mid_q <= mem[mid_addr];
		rd_nxt_q <= mem[nxt_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ptr_q        <= '0;
			seed_q       <= mt64_pkg::SEED_RESET;
			cur_q        <= mt64_pkg::SEED_RESET;
			word_valid_q <= 1'b0;
			word_q       <= '0;
			pend_q       <= 1'b0;
			pend_data_q  <= '0;
		end else begin
			if (seed_valid) begin
				seed_q  <= seed_value;
				cur_q   <= seed_value;
				ptr_q   <= '0;
				state_q <= S_IDLE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (draw_go) begin
							state_q <= S_CALC;
						end
					end
					S_CALC: begin
						cur_q   <= rd_nxt_q;
						ptr_q   <= nxt_addr;
						state_q <= S_IDLE;
					end
				endcase
			end
			// output register and skid entry
			if (state_q == S_CALC && !seed_valid) begin
				if (!word_valid_q || !word_stall) begin
					word_q       <= tempered;
					word_valid_q <= 1'b1;
				end else begin
					pend_data_q <= tempered;
					pend_q      <= 1'b1;
				end
			end else if (word_valid_q && !word_stall) begin
				if (pend_q) begin
					word_q <= pend_data_q;
					pend_q <= 1'b0;
				end else begin
					word_valid_q <= 1'b0;
				end
			end
		end
	end

`include "mersenne_twister_64_generator_unit_assert.svh"

	`MT64_ASSERT_IMP(a_ptr_range, 1'b1, ptr_q <= mt64_pkg::LAST_IDX)
	`MT64_ASSERT_IMP(a_no_draw_in_fill, fill_busy, draw_stall)
	`MT64_ASSERT_NXT(a_calc_delivers, state_q == S_CALC && !seed_valid, state_q == S_IDLE && word_valid)
	`MT64_ASSERT_IMP(a_pend_behind_out, pend_q, word_valid_q)
	`MT64_ASSERT_NXT(a_seed_restarts, seed_valid, fill_busy && ptr_q == '0)

endmodule

`default_nettype wire
